// ----- src/edfs_pkg.sv -----
// Shared types and constants of the EDF periodic task scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package edfs_pkg;

    // Fixed field widths of the stream payloads
    localparam int IDX_W  = 3;
    localparam int VAL_W  = 16;
    localparam int MISS_W = 4;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 48;

    // Operation codes carried on the input tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the accepted request and clear the per-item accumulators
        logic rd_en;    // read the row at rd_addr
        logic proc;     // row of proc_addr is on the read port: update and write back
        logic finish;   // close the item and load the result register
    } edfs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free; // result register can take a new result this cycle
    } edfs_status_t;

endpackage

`default_nettype wire

// ----- src/edfs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Holds the per-slot task rows of the scheduler; no dependencies.
`default_nettype none

module edfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire  logic                      clk,
    input  wire  logic                      wr_en,
    input  wire  logic [ADDR_W-1:0]         wr_addr,
    input  wire  logic [WIDTH-1:0]          wr_data,
    input  wire  logic                      rd_en,
    input  wire  logic [ADDR_W-1:0]         rd_addr,
    output logic       [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/edfs_ctrl.sv -----
// Controller of the EDF scheduler: request handshake, slot scan sequencing, result hand-off.
// Depends on edfs_pkg for the command and status types.
`default_nettype none

module edfs_ctrl
    import edfs_pkg::*;
#(
    parameter int TASK_SLOTS = 8,
    localparam int SLOT_W    = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
    input  wire  logic                  clk,
    input  wire  logic                  rst_n,
    input  wire  logic                  s_axis_tvalid,
    output logic                        s_axis_tready,
    output edfs_cmd_t                   cmd,
    output logic [SLOT_W-1:0]           rd_addr,
    output logic [SLOT_W-1:0]           proc_addr,
    input  wire  edfs_status_t          status
);
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              proc_reg;
    logic [SLOT_W-1:0] proc_addr_reg;
    logic              issue_done;

    assign issue_done    = (cnt_reg == CNT_W'(TASK_SLOTS));
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign rd_addr       = cnt_reg[SLOT_W-1:0];
    assign proc_addr     = proc_addr_reg;

    always_comb
    begin
        cmd.capture = s_axis_tvalid && (state_reg == ST_IDLE);
        cmd.rd_en   = (state_reg == ST_SCAN) && !issue_done;
        cmd.proc    = proc_reg;
        cmd.finish  = (state_reg == ST_FINISH) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (issue_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                // hold until the result register drains
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            proc_reg      <= 1'b0;
            proc_addr_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            proc_reg      <= cmd.rd_en;
            proc_addr_reg <= rd_addr;
        end
    end

endmodule

`default_nettype wire

// ----- src/edfs_dp.sv -----
// Datapath of the EDF scheduler: task row memory, per-slot miss/release update,
// earliest-deadline selection, scalar time state and the result register.
// Depends on edfs_pkg and edfs_ram.
`default_nettype none

module edfs_dp
    import edfs_pkg::*;
#(
    parameter int TASK_SLOTS = 8,
    parameter int TIME_BITS  = 16,
    localparam int SLOT_W    = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
    input  wire  logic                  clk,
    input  wire  logic                  rst_n,
    input  wire  logic                  s_axis_tuser,
    input  wire  logic [S_DATA_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire  logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]         m_axis_tdata,
    input  wire  edfs_cmd_t             cmd,
    input  wire  logic [SLOT_W-1:0]     rd_addr,
    input  wire  logic [SLOT_W-1:0]     proc_addr,
    output edfs_status_t                status
);
    localparam int DL_W     = ((TIME_BITS > VAL_W) ? TIME_BITS : VAL_W) + 1;
    localparam int CNTM_W   = $clog2(TASK_SLOTS + 1);
    localparam int OFF_EXEC = 0;
    localparam int OFF_PER  = VAL_W;
    localparam int OFF_JOBS = 2 * VAL_W;
    localparam int OFF_REL  = 3 * VAL_W;
    localparam int OFF_WORK = 4 * VAL_W;
    localparam int OFF_DL   = 5 * VAL_W;
    localparam int ROW_W    = OFF_DL + DL_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // captured request
    logic                 op_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [VAL_W-1:0]     exec_reg, per_reg, jobs_reg;

    // scalar state
    logic [TASK_SLOTS-1:0] valid_reg, valid_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [VAL_W-1:0]      miss_cnt_reg, miss_cnt_next;
    logic                  lr_idle_reg, lr_idle_next;
    logic [SLOT_W-1:0]     lr_slot_reg, lr_slot_next;

    // per-item accumulators
    logic                  lr_nz_reg, lr_nz_next;
    logic [CNTM_W-1:0]     misses_reg, misses_next;
    logic                  acc_reg, acc_next;
    logic                  cand_vld_reg, cand_vld_next;
    logic [SLOT_W-1:0]     cand_idx_reg, cand_idx_next;
    logic [ROW_W-1:0]      cand_row_reg, cand_row_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0]   out_data_reg, out_data_next;

    // memory ports
    logic [ROW_W-1:0]      rd_data;
    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_addr;
    logic [ROW_W-1:0]      wr_data;

    // slot update
    logic [ROW_W-1:0]      row_rd, row_new, cand_dec_row;
    logic [VAL_W-1:0]      r_exec, r_per, r_jobs, r_rel, r_work;
    logic [DL_W-1:0]       r_dl, cand_dl, t_ext;
    logic [VAL_W-1:0]      cand_work, cand_exec;
    logic                  take, miss, due, slot_match;

    // result fields
    logic [IDX_W-1:0]      f_task;
    logic                  f_idle, f_start, f_resume, f_pre, f_fin, f_done;
    logic [MISS_W-1:0]     f_misses;
    logic [VAL_W-1:0]      f_miss_total, f_tick;

    edfs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TASK_SLOTS)
    ) u_rows (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign status.out_free = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;

    assign t_ext     = DL_W'(now_reg);
    assign cand_dl   = cand_row_reg[OFF_DL +: DL_W];
    assign cand_work = cand_row_reg[OFF_WORK +: VAL_W];
    assign cand_exec = cand_row_reg[OFF_EXEC +: VAL_W];

    always_comb
    begin
        cand_dec_row = cand_row_reg;
        cand_dec_row[OFF_WORK +: VAL_W] = cand_work - VAL_W'(1);
    end

    // Per-slot update of the row on the read port
    always_comb
    begin
        row_rd  = valid_reg[proc_addr] ? rd_data : '0;
        r_exec  = row_rd[OFF_EXEC +: VAL_W];
        r_per   = row_rd[OFF_PER  +: VAL_W];
        r_jobs  = row_rd[OFF_JOBS +: VAL_W];
        r_rel   = row_rd[OFF_REL  +: VAL_W];
        r_work  = row_rd[OFF_WORK +: VAL_W];
        r_dl    = row_rd[OFF_DL   +: DL_W];
        miss    = 1'b0;
        due     = 1'b0;
        take    = 1'b0;
        slot_match = (32'(idx_reg) == 32'(proc_addr));

        if (op_reg == OP_LOAD)
        begin
            // restart: dynamic fields cleared, table written only in the addressed slot
            if (slot_match)
            begin
                r_exec = exec_reg;
                r_per  = per_reg;
                r_jobs = jobs_reg;
            end
            r_rel  = '0;
            r_work = '0;
            r_dl   = '0;
        end
        else
        begin
            // abort a job whose deadline has arrived
            if (r_work != '0 && r_dl <= t_ext)
            begin
                miss   = 1'b1;
                r_work = '0;
            end
            if (r_rel < r_jobs)
            begin
                if (r_rel == '0)
                begin
                    due = (now_reg == '0);
                end
                else
                begin
                    due = (r_per != '0) && (t_ext == r_dl);
                end
            end
            if (due)
            begin
                r_dl   = t_ext + DL_W'(r_per);
                r_work = r_exec;
                r_rel  = r_rel + VAL_W'(1);
            end
            take = (r_work != '0) && (!cand_vld_reg || r_dl < cand_dl);
        end
        row_new = {r_dl, r_work, r_rel, r_jobs, r_per, r_exec};
    end

    always_comb
    begin
        wr_en   = cmd.proc || (cmd.finish && op_reg == OP_TICK && cand_vld_reg);
        wr_addr = cmd.proc ? proc_addr : cand_idx_reg;
        wr_data = cmd.proc ? row_new : cand_dec_row;
    end

    // Result fields
    always_comb
    begin
        f_task       = '0;
        f_idle       = 1'b1;
        f_start      = 1'b0;
        f_resume     = 1'b0;
        f_pre        = 1'b0;
        f_fin        = 1'b0;
        f_misses     = '0;
        f_miss_total = '0;
        f_tick       = '0;
        f_done       = !acc_reg;
        if (op_reg == OP_TICK)
        begin
            f_misses     = MISS_W'(misses_reg);
            f_miss_total = miss_cnt_reg;
            f_tick       = VAL_W'(now_reg);
            if (cand_vld_reg)
            begin
                f_task   = IDX_W'(cand_idx_reg);
                f_idle   = 1'b0;
                f_start  = (cand_work == cand_exec);
                f_resume = !f_start && (lr_idle_reg || lr_slot_reg != cand_idx_reg);
                f_pre    = !lr_idle_reg && lr_slot_reg != cand_idx_reg && lr_nz_reg;
                f_fin    = (cand_work == VAL_W'(1));
                f_done   = !acc_reg && f_fin;
            end
        end
        out_data_next = {3'b000, f_done, f_tick, f_miss_total, f_misses,
                         f_fin, f_pre, f_resume, f_start, f_idle, f_task};
    end

    // Next state of scalars and accumulators
    always_comb
    begin
        valid_next     = valid_reg;
        now_next       = now_reg;
        miss_cnt_next  = miss_cnt_reg;
        lr_idle_next   = lr_idle_reg;
        lr_slot_next   = lr_slot_reg;
        lr_nz_next     = lr_nz_reg;
        misses_next    = misses_reg;
        acc_next       = acc_reg;
        cand_vld_next  = cand_vld_reg;
        cand_idx_next  = cand_idx_reg;
        cand_row_next  = cand_row_reg;
        out_valid_next = out_valid_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.capture)
        begin
            lr_nz_next    = 1'b0;
            misses_next   = '0;
            acc_next      = 1'b0;
            cand_vld_next = 1'b0;
        end

        if (cmd.proc)
        begin
            valid_next[proc_addr] = 1'b1;
            if (op_reg == OP_LOAD)
            begin
                acc_next = acc_reg || (r_jobs != '0);
            end
            else
            begin
                if (miss)
                begin
                    misses_next = misses_reg + CNTM_W'(1);
                    if (miss_cnt_reg != '1)
                    begin
                        miss_cnt_next = miss_cnt_reg + VAL_W'(1);
                    end
                end
                if (!lr_idle_reg && lr_slot_reg == proc_addr)
                begin
                    lr_nz_next = (r_work != '0);
                end
                // a displaced candidate still has work, so the run is not done
                acc_next = acc_reg || (r_rel < r_jobs) ||
                           (r_work != '0 && (!take || cand_vld_reg));
                if (take)
                begin
                    cand_vld_next = 1'b1;
                    cand_idx_next = proc_addr;
                    cand_row_next = row_new;
                end
            end
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            if (op_reg == OP_LOAD)
            begin
                now_next      = '0;
                miss_cnt_next = '0;
                lr_idle_next  = 1'b1;
            end
            else
            begin
                lr_idle_next = !cand_vld_reg;
                lr_slot_next = cand_idx_reg;
                if (now_reg != TIME_MAX)
                begin
                    now_next = now_reg + TIME_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            now_reg       <= '0;
            miss_cnt_reg  <= '0;
            lr_idle_reg   <= 1'b1;
            lr_slot_reg   <= '0;
            lr_nz_reg     <= 1'b0;
            misses_reg    <= '0;
            acc_reg       <= 1'b0;
            cand_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            now_reg       <= now_next;
            miss_cnt_reg  <= miss_cnt_next;
            lr_idle_reg   <= lr_idle_next;
            lr_slot_reg   <= lr_slot_next;
            lr_nz_reg     <= lr_nz_next;
            misses_reg    <= misses_next;
            acc_reg       <= acc_next;
            cand_vld_reg  <= cand_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= s_axis_tuser;
            idx_reg  <= s_axis_tdata[IDX_W-1:0];
            exec_reg <= s_axis_tdata[IDX_W +: VAL_W];
            per_reg  <= s_axis_tdata[IDX_W + VAL_W +: VAL_W];
            jobs_reg <= s_axis_tdata[IDX_W + 2 * VAL_W +: VAL_W];
        end
        cand_idx_reg <= cand_idx_next;
        cand_row_reg <= cand_row_next;
        if (cmd.finish)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/edf_periodic_task_scheduler_unit.sv -----
// Top level of the periodic-task earliest-deadline-first scheduler.
// Instantiates edfs_ctrl and edfs_dp; types and constants from edfs_pkg.
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------------
//  s_axis   | in        | tuser: operation; tdata: task_index, exec_time, period,
//           |           |   job_count
//  m_axis   | out       | tdata: running_task, cpu_idle, job_started, job_resumed,
//           |           |   preempted, job_finished, misses_now, miss_total,
//           |           |   tick_time, all_done
//
// For each request (load or tick), between acceptance and its registered result,
// the task row memory is swept one slot per cycle through its single read port,
// then on a tick the selected row is written back.
// The block is ready for the next request as soon as that result is registered.
// Reset clears the task table through per-slot valid bits; no clearing pass.
// A new request is taken while a result still waits on m_axis; a stalled
// output holds the block at its write-back step.
`default_nettype none

module edf_periodic_task_scheduler_unit
    import edfs_pkg::*;
#(
    parameter int TASK_SLOTS = 8,
    parameter int TIME_BITS  = 16
) (
    input  wire  logic                  clk,
    input  wire  logic                  rst_n,
    input  wire  logic                  s_axis_tvalid,
    output logic                        s_axis_tready,
    // [2:0] task_index, [18:3] exec_time, [34:19] period, [50:35] job_count, rest zero
    input  wire  logic [S_DATA_W-1:0]   s_axis_tdata,
    // [0] operation
    input  wire  logic                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire  logic                  m_axis_tready,
    // [2:0] running_task, [3] cpu_idle, [4] job_started, [5] job_resumed,
    // [6] preempted, [7] job_finished, [11:8] misses_now, [27:12] miss_total,
    // [43:28] tick_time, [44] all_done, rest zero
    output logic [M_DATA_W-1:0]         m_axis_tdata
);
    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    edfs_cmd_t          cmd;
    edfs_status_t       status;
    logic [SLOT_W-1:0]  rd_addr;
    logic [SLOT_W-1:0]  proc_addr;

    edfs_ctrl #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .proc_addr     (proc_addr),
        .status        (status)
    );

    edfs_dp #(
        .TASK_SLOTS (TASK_SLOTS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .proc_addr     (proc_addr),
        .status        (status)
    );

endmodule

`default_nettype wire

// ----- tb/edf_schedule_checker.sv -----
// Watches both streams of the EDF scheduler, predicts each result and compares it.
// Depends on edfs_pkg for operation codes and bus widths.
module edf_schedule_checker
    import edfs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    input  logic                s_axis_tuser,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [M_DATA_W-1:0] m_axis_tdata,
    output int                  mismatch_count,
    output int                  pending
);

    localparam int SLOTS      = 8;
    localparam int IDLE_SLOT  = SLOTS;
    localparam int RING_DEPTH = 8;

    // Result word from the top bit down, so it overlays m_axis_tdata[44:0]
    typedef struct packed {
        logic        all_done;
        logic [15:0] tick_time;
        logic [15:0] miss_total;
        logic [3:0]  misses_now;
        logic        job_finished;
        logic        preempted;
        logic        job_resumed;
        logic        job_started;
        logic        cpu_idle;
        logic [2:0]  running_task;
    } sched_result_t;

    logic [15:0] slot_exec   [SLOTS];
    logic [15:0] slot_period [SLOTS];
    logic [15:0] slot_jobs   [SLOTS];
    logic [15:0] jobs_out    [SLOTS];
    logic [15:0] work_left   [SLOTS];
    logic [16:0] deadline    [SLOTS];
    logic [15:0] clock_now;
    logic [15:0] miss_tally;
    int          last_slot;

    sched_result_t sched_ring [RING_DEPTH];
    int            ring_rd;
    int            ring_wr;
    int            ring_cnt;
    sched_result_t pred;
    sched_result_t want;
    sched_result_t got;
    int            errs;

    function automatic void restart_clock();
        for (int i = 0; i < SLOTS; i++)
        begin
            jobs_out[i]  = '0;
            work_left[i] = '0;
            deadline[i]  = '0;
        end
        clock_now  = '0;
        miss_tally = '0;
        last_slot  = IDLE_SLOT;
    endfunction

    function automatic logic table_drained();
        for (int i = 0; i < SLOTS; i++)
        begin
            if (jobs_out[i] < slot_jobs[i] || work_left[i] != 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic sched_result_t schedule_request(logic op, logic [2:0] slot,
                                                       logic [15:0] exec_t,
                                                       logic [15:0] per,
                                                       logic [15:0] jobs);
        sched_result_t r;
        logic [15:0]   t;
        int            sel;
        int            misses;
        logic          due;
        logic          started;
        r = '0;
        if (op == OP_LOAD)
        begin
            restart_clock();
            slot_exec[slot]   = exec_t;
            slot_period[slot] = per;
            slot_jobs[slot]   = jobs;
            r.cpu_idle = 1'b1;
            r.all_done = table_drained();
            return r;
        end
        t      = clock_now;
        sel    = IDLE_SLOT;
        misses = 0;
        // abort jobs whose deadline has arrived
        for (int i = 0; i < SLOTS; i++)
        begin
            if (work_left[i] != 0 && deadline[i] <= {1'b0, t})
            begin
                work_left[i] = '0;
                misses++;
                if (miss_tally != 16'hFFFF)
                    miss_tally = miss_tally + 16'd1;
            end
        end
        // release due jobs
        for (int i = 0; i < SLOTS; i++)
        begin
            if (jobs_out[i] < slot_jobs[i])
            begin
                if (jobs_out[i] == 0)
                    due = (t == 0);
                else
                    due = (slot_period[i] != 0 && {1'b0, t} == deadline[i]);
                if (due)
                begin
                    deadline[i]  = {1'b0, t} + {1'b0, slot_period[i]};
                    work_left[i] = slot_exec[i];
                    jobs_out[i]  = jobs_out[i] + 16'd1;
                end
            end
        end
        // earliest deadline wins, lowest slot on ties
        for (int i = 0; i < SLOTS; i++)
        begin
            if (work_left[i] != 0 && (sel == IDLE_SLOT || deadline[i] < deadline[sel]))
                sel = i;
        end
        if (sel != IDLE_SLOT)
        begin
            started        = (work_left[sel] == slot_exec[sel]);
            r.job_started  = started;
            r.job_resumed  = !started && last_slot != sel;
            r.preempted    = last_slot < IDLE_SLOT && last_slot != sel
                             && work_left[last_slot] != 0;
            work_left[sel] = work_left[sel] - 16'd1;
            r.job_finished = (work_left[sel] == 0);
            r.running_task = 3'(sel);
        end
        else
            r.cpu_idle = 1'b1;
        last_slot = sel;
        if (clock_now != 16'hFFFF)
            clock_now = clock_now + 16'd1;
        r.misses_now = 4'(misses);
        r.miss_total = miss_tally;
        r.tick_time  = t;
        r.all_done   = table_drained();
        return r;
    endfunction

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_exec[i]   = '0;
                slot_period[i] = '0;
                slot_jobs[i]   = '0;
            end
            restart_clock();
            ring_rd  = 0;
            ring_wr  = 0;
            ring_cnt = 0;
            errs = 0;
            mismatch_count <= 0;
            pending        <= 0;
        end
        else
        begin
            // take the result first so a request in the same cycle cannot cover for it
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (ring_cnt == 0)
                begin
                    $error("result with no request outstanding: %h", m_axis_tdata);
                    errs++;
                end
                else
                begin
                    want     = sched_ring[ring_rd];
                    ring_rd  = (ring_rd + 1) % RING_DEPTH;
                    ring_cnt = ring_cnt - 1;
                    got  = m_axis_tdata[44:0];
                    check_field("running_task", want.running_task, got.running_task);
                    check_field("cpu_idle", want.cpu_idle, got.cpu_idle);
                    check_field("job_started", want.job_started, got.job_started);
                    check_field("job_resumed", want.job_resumed, got.job_resumed);
                    check_field("preempted", want.preempted, got.preempted);
                    check_field("job_finished", want.job_finished, got.job_finished);
                    check_field("misses_now", want.misses_now, got.misses_now);
                    check_field("miss_total", want.miss_total, got.miss_total);
                    check_field("tick_time", want.tick_time, got.tick_time);
                    check_field("all_done", want.all_done, got.all_done);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pred = schedule_request(s_axis_tuser, s_axis_tdata[2:0],
                                        s_axis_tdata[18:3],
                                        s_axis_tdata[34:19],
                                        s_axis_tdata[50:35]);
                if (ring_cnt == RING_DEPTH)
                begin
                    $error("too many requests outstanding");
                    errs++;
                end
                else
                begin
                    sched_ring[ring_wr] = pred;
                    ring_wr  = (ring_wr + 1) % RING_DEPTH;
                    ring_cnt = ring_cnt + 1;
                end
            end
            mismatch_count <= errs;
            pending        <= ring_cnt;
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Stimulus and verdict for the EDF periodic task scheduler.
// Depends on edfs_pkg, edf_periodic_task_scheduler_unit and edf_schedule_checker.
module testbench;
    import edfs_pkg::*;

    localparam int SLOTS          = 8;
    localparam int PHASE_ITEMS    = 190;
    localparam int RANDOM_ITEMS   = 500;
    localparam int HOLD_ITEM      = 420;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4 * (SLOTS + 3);
    localparam int TAIL_TICKS     = 24;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                s_axis_tuser = OP_TICK;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;

    int mismatches;
    int pending;
    int sent = 0;
    int quiet_cycles = 0;
    int tx_idle_pct = 22;
    int rx_idle_pct = 81;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    always #6 clk = ~clk;

    edf_periodic_task_scheduler_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    edf_schedule_checker u_sched_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatches),
        .pending        (pending)
    );

    // Result side: random back-pressure, or one long hold-off on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(logic op, logic [2:0] slot, logic [15:0] exec_t,
                                logic [15:0] per, logic [15:0] jobs);
        logic [S_DATA_W-1:0] word;
        word = '0;
        word[2:0]   = slot;
        word[18:3]  = exec_t;
        word[34:19] = per;
        word[50:35] = jobs;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent++;
        if (sent == PHASE_ITEMS)
        begin
            tx_idle_pct = 81;
            rx_idle_pct = 22;
        end
        else if (sent == 2 * PHASE_ITEMS)
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    task automatic load_slot(logic [2:0] slot, logic [15:0] exec_t, logic [15:0] per,
                             logic [15:0] jobs);
        send_request(OP_LOAD, slot, exec_t, per, jobs);
    endtask

    // Tick fields are don't-care: fill them with noise
    task automatic tick(int n);
        repeat (n)
            send_request(OP_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
    endtask

    // Mostly small values, with zero, all-ones and full-range values mixed in
    function automatic logic [15:0] pick_value(int lo, int hi);
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return 16'd0;
        if (r < 12)
            return 16'($urandom);
        if (r < 14)
            return 16'hFFFF;
        return 16'($urandom_range(hi, lo));
    endfunction

    // Fill the table, then run it for a while; a few stray loads break the run
    task automatic run_scenario();
        int active;
        int ticks;
        active = $urandom_range(1, SLOTS);
        for (int s = 0; s < SLOTS; s++)
        begin
            if ($urandom_range(99) >= 10)
                load_slot(3'(s), pick_value(1, 4), pick_value(2, 16),
                          ($urandom_range(1, SLOTS) <= active) ? pick_value(1, 5) : 16'd0);
        end
        ticks = $urandom_range(8, 60);
        repeat (ticks)
        begin
            if ($urandom_range(99) < 4)
                load_slot(3'($urandom), pick_value(1, 4), pick_value(2, 16),
                          pick_value(0, 5));
            else
                tick(1);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        tick(1);
        // every slot misses on the same tick; slot 7 carries the largest values
        for (int s = 0; s < SLOTS - 1; s++)
            load_slot(3'(s), 16'd2, 16'd1, 16'd1);
        load_slot(3'd7, 16'hFFFF, 16'd1, 16'hFFFF);
        tick(2);
        // zero execution time, zero period, disabled slot
        load_slot(3'd0, 16'd0, 16'd5, 16'd2);
        load_slot(3'd1, 16'd3, 16'd0, 16'd4);
        load_slot(3'd7, 16'd1, 16'd2, 16'd0);
        tick(4);

        while (sent < RANDOM_ITEMS)
        begin
            run_scenario();
            if (!hold_done && sent >= HOLD_ITEM)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
        end

        // long-period task beside a task with the largest execution time and period
        for (int s = 2; s < SLOTS; s++)
            load_slot(3'(s), 16'd1, 16'd1, 16'd0);
        load_slot(3'd1, 16'd1, 16'd40000, 16'hFFFF);
        load_slot(3'd0, 16'hFFFF, 16'hFFFF, 16'd3);
        tick(TAIL_TICKS);
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
